>>> rtl/core/tpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, register indexes and constants of the time payload decoder.
// ----------------------------------------------------------------------------
package tpc_pkg;

  typedef enum logic [1:0] {
    FMT_NONE  = 2'd0,
    FMT_FULL  = 2'd1,
    FMT_SHORT = 2'd2,
    FMT_EPOCH = 2'd3
  } fmt_e;

  typedef enum logic [0:0] {
    CFG_ZONE    = 1'd0,
    CFG_CENTURY = 1'd1
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] ZONE_RESET    = 16'd28800;
  localparam logic [15:0] CENTURY_RESET = 16'd2000;
  localparam logic [31:0] SWAP_LIMIT    = 32'd1000000000;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  weekday;
    logic [7:0]  hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
  } cal_t;

  typedef struct packed {
    logic        vld_res;
    fmt_e        fmt;
    logic [31:0] ts;
    cal_t        cal;
  } item_t;

  // (153 * mp + 2) / 5, days before the month counted from March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/tpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_front
// Holds the configuration registers, accepts payloads and classifies them by
// length; byte formats are unpacked here, epoch stamps are ordered and offset.
// ----------------------------------------------------------------------------
module tpc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [63:0]                    payload_i,
  input  logic [3:0]                     length_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output tpc_pkg::item_t                 item_o
);
  import tpc_pkg::*;

  logic [15:0] zone_q, zone_d;
  logic [15:0] cent_q, cent_d;
  logic [7:0]  b [8];
  logic [31:0] le, be;

  always_comb begin
    zone_d = zone_q;
    cent_d = cent_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZONE:    zone_d = cfg_wdata_i;
        CFG_CENTURY: cent_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= ZONE_RESET;
      cent_q <= CENTURY_RESET;
    end else begin
      zone_q <= zone_d;
      cent_q <= cent_d;
    end
  end

  for (genvar i = 0; i < 8; i++) begin : g_byte
    assign b[i] = payload_i[8*i +: 8];
  end

  assign le = {b[3], b[2], b[1], b[0]};
  assign be = {b[0], b[1], b[2], b[3]};

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o = '0;
    if (length_i >= 4'd8) begin
      item_o.vld_res     = 1'b1;
      item_o.fmt         = FMT_FULL;
      item_o.cal.year    = {b[0], b[1]};
      item_o.cal.month   = b[2];
      item_o.cal.day     = b[3];
      item_o.cal.hours   = b[4];
      item_o.cal.minutes = b[5];
      item_o.cal.seconds = b[6];
      item_o.cal.weekday = b[7];
    end else if (length_i == 4'd7) begin
      item_o.vld_res     = 1'b1;
      item_o.fmt         = FMT_SHORT;
      item_o.cal.year    = cent_q + {8'd0, b[0]};
      item_o.cal.month   = b[1];
      item_o.cal.day     = b[2];
      item_o.cal.hours   = b[3];
      item_o.cal.minutes = b[4];
      item_o.cal.seconds = b[5];
      item_o.cal.weekday = b[6];
    end else if (length_i == 4'd4) begin
      item_o.vld_res = 1'b1;
      item_o.fmt     = FMT_EPOCH;
      item_o.ts      = ((le < SWAP_LIMIT) ? be : le) + {16'd0, zone_q};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tpc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_queue
// Short register queue between the classifier and the conversion pipeline.
// ----------------------------------------------------------------------------
module tpc_queue #(
  parameter int unsigned Depth = tpc_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tpc_pkg::item_t item_o
);
  import tpc_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_back
// Ten-stage civil date pipeline; byte formats ride along unchanged. The last
// stage is the output register. Divides by constants use reciprocal products.
// ----------------------------------------------------------------------------
module tpc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tpc_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           vld_res_o,
  output tpc_pkg::fmt_e  fmt_o,
  output tpc_pkg::cal_t  cal_o
);
  import tpc_pkg::*;

  localparam int unsigned NST = 10;

  localparam logic [25:0] M_DAY  = 26'd50903317; // 2^35 / 675
  localparam logic [12:0] M_225  = 13'd4661;     // 2^20 / 225
  localparam logic [16:0] M_7    = 17'd74899;    // 2^19 / 7
  localparam logic [17:0] M_1460 = 18'd183860;   // 2^28 / 1460
  localparam logic [18:0] M_365  = 19'd367720;   // 2^27 / 365
  localparam logic [10:0] M_15   = 11'd1093;     // 2^14 / 15
  localparam logic [10:0] M_153  = 11'd1714;     // 2^18 / 153

  typedef struct packed {
    logic        vld_res;
    fmt_e        fmt;
    cal_t        cal;
    logic [31:0] t;
    logic [50:0] pd;
    logic [15:0] days;
    logic [16:0] rem;
    logic [2:0]  era;
    logic [17:0] doe;
    logic [25:0] ph;
    logic [32:0] pw;
    logic [35:0] p1460;
    logic [2:0]  c4;
    logic        f;
    logic [4:0]  hours;
    logic [12:0] wq;
    logic [17:0] a;
    logic [11:0] r2;
    logic [2:0]  wd;
    logic [36:0] pa;
    logic [20:0] pm;
    logic [8:0]  yoe;
    logic [5:0]  minutes;
    logic [8:0]  doy;
    logic [11:0] y;
    logic [5:0]  sec;
    logic [21:0] pmp;
  } pl_t;

  pl_t  st_q [NST];
  pl_t  nx   [NST];
  logic vld_q [NST];
  logic en;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = vld_q[NST-1];
  assign vld_res_o   = st_q[NST-1].vld_res;
  assign fmt_o       = st_q[NST-1].fmt;
  assign cal_o       = st_q[NST-1].cal;

  always_comb begin
    logic [19:0] z;
    logic [2:0]  era_l;
    logic [6:0]  q1460;
    logic [1:0]  yq;
    logic [10:0] x5;
    logic [3:0]  mp;
    logic [3:0]  mon;
    logic [4:0]  dd;
    logic [11:0] yfin;

    // days = (t >> 7) / 675
    nx[0]         = '0;
    nx[0].vld_res = q_item_i.vld_res;
    nx[0].fmt     = q_item_i.fmt;
    nx[0].cal     = q_item_i.cal;
    nx[0].t       = q_item_i.ts;
    nx[0].pd      = 51'(q_item_i.ts[31:7]) * 51'(M_DAY);

    nx[1]      = st_q[0];
    nx[1].days = st_q[0].pd[50:35];

    // second of day, era and day of era
    nx[2]     = st_q[1];
    nx[2].rem = 17'(st_q[1].t - 32'(st_q[1].days) * 32'd86400);
    z = 20'(st_q[1].days) + 20'd719468;
    if (z >= 20'd730485)      era_l = 3'd5;
    else if (z >= 20'd584388) era_l = 3'd4;
    else if (z >= 20'd438291) era_l = 3'd3;
    else if (z >= 20'd292194) era_l = 3'd2;
    else if (z >= 20'd146097) era_l = 3'd1;
    else                      era_l = 3'd0;
    nx[2].era = era_l;
    nx[2].doe = 18'(z - 20'(era_l) * 20'd146097);

    nx[3]       = st_q[2];
    nx[3].ph    = 26'(st_q[2].rem[16:4]) * 26'(M_225);
    nx[3].pw    = 33'(st_q[2].days + 16'd4) * 33'(M_7);
    nx[3].p1460 = 36'(st_q[2].doe) * 36'(M_1460);
    if (st_q[2].doe >= 18'd146096)      nx[3].c4 = 3'd4;
    else if (st_q[2].doe >= 18'd109572) nx[3].c4 = 3'd3;
    else if (st_q[2].doe >= 18'd73048)  nx[3].c4 = 3'd2;
    else if (st_q[2].doe >= 18'd36524)  nx[3].c4 = 3'd1;
    else                                nx[3].c4 = 3'd0;
    nx[3].f = (st_q[2].doe == 18'd146096);

    nx[4]       = st_q[3];
    nx[4].hours = st_q[3].ph[24:20];
    nx[4].wq    = st_q[3].pw[31:19];
    q1460       = st_q[3].p1460[34:28];
    nx[4].a     = st_q[3].doe - 18'(q1460) + 18'(st_q[3].c4) - 18'(st_q[3].f);

    nx[5]    = st_q[4];
    nx[5].r2 = 12'(st_q[4].rem - 17'(st_q[4].hours) * 17'd3600);
    nx[5].wd = 3'((st_q[4].days + 16'd4) - 16'(st_q[4].wq) * 16'd7);
    nx[5].pa = 37'(st_q[4].a) * 37'(M_365);

    nx[6]     = st_q[5];
    nx[6].pm  = 21'(st_q[5].r2[11:2]) * 21'(M_15);
    nx[6].yoe = st_q[5].pa[35:27];

    nx[7]         = st_q[6];
    nx[7].minutes = st_q[6].pm[19:14];
    if (st_q[6].yoe >= 9'd300)      yq = 2'd3;
    else if (st_q[6].yoe >= 9'd200) yq = 2'd2;
    else if (st_q[6].yoe >= 9'd100) yq = 2'd1;
    else                            yq = 2'd0;
    nx[7].doy = 9'(st_q[6].doe - (18'(st_q[6].yoe) * 18'd365
                + 18'(st_q[6].yoe[8:2]) - 18'(yq)));
    nx[7].y   = 12'(st_q[6].yoe) + 12'(st_q[6].era) * 12'd400;

    nx[8]     = st_q[7];
    nx[8].sec = 6'(st_q[7].r2 - 12'(st_q[7].minutes) * 12'd60);
    x5        = 11'(st_q[7].doy) * 11'd5 + 11'd2;
    nx[8].pmp = 22'(x5) * 22'(M_153);

    // month, day and year correction for January and February
    nx[9] = st_q[8];
    mp    = st_q[8].pmp[21:18];
    dd    = 5'(st_q[8].doy - month_start(mp) + 9'd1);
    mon   = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    yfin  = st_q[8].y + ((mon <= 4'd2) ? 12'd1 : 12'd0);
    if (st_q[8].fmt == FMT_EPOCH) begin
      nx[9].cal.year    = 16'(yfin);
      nx[9].cal.month   = 8'(mon);
      nx[9].cal.day     = 8'(dd);
      nx[9].cal.weekday = 8'(st_q[8].wd);
      nx[9].cal.hours   = 8'(st_q[8].hours);
      nx[9].cal.minutes = 8'(st_q[8].minutes);
      nx[9].cal.seconds = 8'(st_q[8].sec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= q_valid_i;
      for (int k = 1; k < NST; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        st_q[k] <= nx[k];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/time_payload_to_calendar.sv
`default_nettype none
// ----------------------------------------------------------------------------
// time_payload_to_calendar
// Decodes time-sync payloads (full, short and epoch formats) into calendar
// date, time and weekday.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o | payload_i, length_i
//  out     | out_valid_o/out_ready_i | valid_res_o, format_o, year_o ..
//  cfg     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  One transaction per cycle sustained while results are taken; a transaction
//  passes the queue write and the ten-stage conversion pipeline, whose last
//  stage is the output register. The pipeline advances as a whole and holds
//  while a result waits; the QueueDepth-entry queue keeps accepting until full.
//  Reset clears control state and loads zone 28800 s, century base 2000.
// ----------------------------------------------------------------------------
module time_payload_to_calendar #(
  parameter int unsigned QueueDepth = tpc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [63:0]                    payload_i,
  input  logic [3:0]                     length_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           valid_res_o,
  output logic [1:0]                     format_o,
  output logic [15:0]                    year_o,
  output logic [7:0]                     month_o,
  output logic [7:0]                     day_o,
  output logic [7:0]                     weekday_o,
  output logic [7:0]                     hours_o,
  output logic [7:0]                     minutes_o,
  output logic [7:0]                     seconds_o
);
  import tpc_pkg::*;

  logic  q_push, q_full, q_pop, q_valid;
  item_t f_item, q_item;
  fmt_e  fmt;
  cal_t  cal;

  tpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .payload_i   (payload_i),
    .length_i    (length_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .item_o      (f_item)
  );

  tpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .vld_res_o   (valid_res_o),
    .fmt_o       (fmt),
    .cal_o       (cal)
  );

  assign format_o  = fmt;
  assign year_o    = cal.year;
  assign month_o   = cal.month;
  assign day_o     = cal.day;
  assign weekday_o = cal.weekday;
  assign hours_o   = cal.hours;
  assign minutes_o = cal.minutes;
  assign seconds_o = cal.seconds;

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> q_valid)
    else $error("queue empty after a push");

  a_valid_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_res_o == (fmt != FMT_NONE)))
    else $error("valid_res disagrees with format");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fmt == FMT_NONE) |-> (cal == '0))
    else $error("unknown format with nonzero fields");

  a_epoch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fmt == FMT_EPOCH) |->
      (month_o >= 8'd1 && month_o <= 8'd12 && day_o >= 8'd1 && day_o <= 8'd31 &&
       hours_o < 8'd24 && minutes_o < 8'd60 && seconds_o < 8'd60 &&
       weekday_o < 8'd7))
    else $error("epoch result out of range");

endmodule
`default_nettype wire

>>> bench/calendar_checker.sv
// ----------------------------------------------------------------------------
// calendar_checker
// Watches the payload, result and register channels of the time payload
// decoder, predicts each calendar result from the accepted payload and the
// current zone/century registers, and compares results in order.
// ----------------------------------------------------------------------------
module calendar_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [63:0]                    payload_i,
  input  logic [3:0]                     length_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           valid_res_i,
  input  logic [1:0]                     format_i,
  input  logic [15:0]                    year_i,
  input  logic [7:0]                     month_i,
  input  logic [7:0]                     day_i,
  input  logic [7:0]                     weekday_i,
  input  logic [7:0]                     hours_i,
  input  logic [7:0]                     minutes_i,
  input  logic [7:0]                     seconds_i,
  output int unsigned                    outstanding_o,
  output int unsigned                    results_o,
  output int unsigned                    mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  typedef struct packed {
    logic vld;
    fmt_e fmt;
    cal_t cal;
  } decoded_t;

  logic [15:0] zone_q;
  logic [15:0] century_q;
  decoded_t    calendar_q[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;

  assign mismatches_o = mismatch_count;
  assign results_o    = result_count;

  function automatic decoded_t decode_payload(input logic [63:0] p, input logic [3:0] len);
    decoded_t    d;
    logic [31:0] stamp;
    int unsigned days, sod, z, era, doe, yoe, yr, doy, mp, dd, mm;
    d = '0;
    if (len >= 4'd8) begin
      d.vld         = 1'b1;
      d.fmt         = FMT_FULL;
      d.cal.year    = {p[7:0], p[15:8]};
      d.cal.month   = p[23:16];
      d.cal.day     = p[31:24];
      d.cal.hours   = p[39:32];
      d.cal.minutes = p[47:40];
      d.cal.seconds = p[55:48];
      d.cal.weekday = p[63:56];
    end else if (len == 4'd7) begin
      d.vld         = 1'b1;
      d.fmt         = FMT_SHORT;
      d.cal.year    = century_q + {8'd0, p[7:0]};
      d.cal.month   = p[15:8];
      d.cal.day     = p[23:16];
      d.cal.hours   = p[31:24];
      d.cal.minutes = p[39:32];
      d.cal.seconds = p[47:40];
      d.cal.weekday = p[55:48];
    end else if (len == 4'd4) begin
      stamp = p[31:0];
      if (stamp < SWAP_LIMIT) stamp = {p[7:0], p[15:8], p[23:16], p[31:24]};
      stamp = stamp + {16'd0, zone_q};
      days  = stamp / 86400;
      sod   = stamp % 86400;
      z     = days + 719468;
      era   = z / 146097;
      doe   = z - era * 146097;
      yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr    = yoe + era * 400;
      doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp    = (5 * doy + 2) / 153;
      dd    = doy - (153 * mp + 2) / 5 + 1;
      mm    = (mp < 10) ? mp + 3 : mp - 9;
      if (mm <= 2) yr = yr + 1;
      d.vld         = 1'b1;
      d.fmt         = FMT_EPOCH;
      d.cal.year    = 16'(yr);
      d.cal.month   = 8'(mm);
      d.cal.day     = 8'(dd);
      d.cal.weekday = 8'((days + 4) % 7);
      d.cal.hours   = 8'(sod / 3600);
      d.cal.minutes = 8'((sod % 3600) / 60);
      d.cal.seconds = 8'(sod % 60);
    end
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                result_count, name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    decoded_t want;
    if (!rst_ni) begin
      zone_q    = ZONE_RESET;
      century_q = CENTURY_RESET;
      calendar_q.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ZONE:    zone_q = cfg_wdata_i;
          CFG_CENTURY: century_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        result_count++;
        if (calendar_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing pending (format %0d)",
                                    result_count, format_i));
        end else begin
          want = calendar_q.pop_front();
          check_field("valid_res", valid_res_i, want.vld);
          check_field("format", format_i, want.fmt);
          check_field("year", year_i, want.cal.year);
          check_field("month", month_i, want.cal.month);
          check_field("day", day_i, want.cal.day);
          check_field("weekday", weekday_i, want.cal.weekday);
          check_field("hours", hours_i, want.cal.hours);
          check_field("minutes", minutes_i, want.cal.minutes);
          check_field("seconds", seconds_i, want.cal.seconds);
        end
      end
      if (in_valid_i && in_ready_i) calendar_q.push_back(decode_payload(payload_i, length_i));
      outstanding_o <= calendar_q.size();
    end
  end

endmodule

>>> bench/time_payload_to_calendar_tb.sv
// ----------------------------------------------------------------------------
// time_payload_to_calendar_tb
// Drives directed and random time-sync payloads (full, short, epoch and
// unknown lengths) through the decoder under several zone/century settings
// and sender/receiver idle mixes; the checker flags any result deviation.
// ----------------------------------------------------------------------------
module time_payload_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [63:0]           payload_i;
  logic [3:0]            length_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  valid_res_o;
  logic [1:0]            format_o;
  logic [15:0]           year_o;
  logic [7:0]            month_o;
  logic [7:0]            day_o;
  logic [7:0]            weekday_o;
  logic [7:0]            hours_o;
  logic [7:0]            minutes_o;
  logic [7:0]            seconds_o;

  int unsigned outstanding, results, mismatches;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_full = 0, n_short = 0, n_epoch = 0, n_unknown = 0;

  time_payload_to_calendar dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .payload_i, .length_i,
    .out_valid_o, .out_ready_i, .valid_res_o, .format_o, .year_o, .month_o,
    .day_o, .weekday_o, .hours_o, .minutes_o, .seconds_o
  );

  calendar_checker calendar_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .payload_i, .length_i,
    .out_valid_i(out_valid_o), .out_ready_i, .valid_res_i(valid_res_o),
    .format_i(format_o), .year_i(year_o), .month_i(month_o), .day_i(day_o),
    .weekday_i(weekday_o), .hours_i(hours_o), .minutes_i(minutes_o),
    .seconds_i(seconds_o),
    .outstanding_o(outstanding), .results_o(results), .mismatches_o(mismatches)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_payload(input logic [63:0] p, input logic [3:0] len);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    payload_i  <= p;
    length_i   <= len;
    if (len >= 4'd8) n_full++;
    else if (len == 4'd7) n_short++;
    else if (len == 4'd4) n_epoch++;
    else n_unknown++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    logic [63:0] p;
    logic [3:0]  len;
    logic [31:0] stamp;
    int unsigned pick;
    p    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 30) begin
      len = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
    end else if (pick < 55) begin
      len = 4'd7;
    end else if (pick < 90) begin
      len = 4'd4;
      case ($urandom_range(3))
        0:       stamp = 32'($urandom_range(999999999, 0));
        1:       stamp = 32'hFFFF_0000 | 32'($urandom_range(65535));
        default: stamp = $urandom;
      endcase
      p[31:0] = stamp;
    end else begin
      len = 4'($urandom_range(5));
      if (len >= 4'd4) len = len + 4'd1;
    end
    push_payload(p, len);
  endtask

  // hold the sender until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic program_registers(input logic [15:0] zone, input logic [15:0] century);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ZONE;
    cfg_wdata_i <= zone;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CENTURY;
    cfg_wdata_i <= century;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    #3_000_000;
    $display("Timeout with %0d results pending", outstanding);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [15:0] zone, century;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ZONE;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    payload_i   = '0;
    length_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed items at reset register values
    push_payload(64'h0, 4'd8);
    push_payload('1, 4'd8);
    push_payload(64'h031E_2D17_0F06_E807, 4'd8);
    push_payload({$urandom, $urandom}, 4'd9);
    push_payload({$urandom, $urandom}, 4'd15);
    push_payload(64'hFF00_0000_0000_0000, 4'd7);
    push_payload('1, 4'd7);
    push_payload(64'h0006_1E2D_170F_0618, 4'd7);
    push_payload(64'hDEAD_BEEF_3B9A_CA00, 4'd4);
    push_payload(64'h0000_0000_3B9A_C9FF, 4'd4);
    push_payload(64'hFFFF_FFFF_0000_0000, 4'd4);
    push_payload(64'h0000_0000_FFFF_FFFF, 4'd4);
    push_payload(64'h0000_0000_8000_0000, 4'd4);
    push_payload({32'h0, 32'd1709164800}, 4'd4);
    push_payload({32'h0, 32'd4102444800}, 4'd4);
    push_payload(64'h1234_5678_00C9_DF65, 4'd4);
    push_payload('1, 4'd0);
    push_payload('1, 4'd1);
    push_payload('1, 4'd2);
    push_payload('1, 4'd3);
    push_payload('1, 4'd5);
    push_payload('1, 4'd6);
    push_payload(64'hAAAA_AAAA_AAAA_AAAA, 4'd8);
    push_payload(64'h5555_5555_5555_5555, 4'd8);

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: begin zone = 16'd0;     century = 16'd0;     end
        1: begin zone = 16'd50400; century = 16'd65535; end
        2: begin zone = 16'd65535; century = 16'd1900;  end
        3: begin
          zone    = 16'($urandom_range(50400));
          century = 16'($urandom_range(65535));
        end
        4: begin zone = ZONE_RESET; century = CENTURY_RESET; end
        default: begin zone = 16'd1; century = 16'd255; end
      endcase
      program_registers(zone, century);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 14; stall_pct = 14; end
      endcase
      repeat (275) send_random_item();
    end

    drain_results();
    repeat (24) @(posedge clk_i);
    $display("Run covered %0d transactions: %0d full, %0d short, %0d epoch, %0d unknown length",
             n_full + n_short + n_epoch + n_unknown, n_full, n_short, n_epoch, n_unknown);
    $display("%0d results compared over 7 register settings with sender gaps and stalls",
             results);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
